>>> rtl/uqd_pkg.sv
`timescale 1ns / 1ps

package uqd_pkg;

    localparam int MaxItems  = 4;
    localparam int ItemIdxW  = $clog2(MaxItems);
    localparam int ItemCntW  = $clog2(MaxItems + 1);
    localparam int FifoDepth = 4;
    localparam int FifoPtrW  = $clog2(FifoDepth);
    localparam int FifoCntW  = $clog2(FifoDepth + 1);

    localparam logic [7:0] ChPercent = 8'h25;
    localparam logic [7:0] ChPlus    = 8'h2B;
    localparam logic [7:0] ChAmp     = 8'h26;
    localparam logic [7:0] ChEqual   = 8'h3D;
    localparam logic [7:0] ChSpace   = 8'h20;
    localparam logic [7:0] ChZero    = 8'h30;
    localparam logic [7:0] ChNine    = 8'h39;
    localparam logic [7:0] ChLowA    = 8'h61;
    localparam logic [7:0] ChLowF    = 8'h66;
    localparam logic [7:0] ChUpA     = 8'h41;
    localparam logic [7:0] ChUpF     = 8'h46;
    localparam logic [4:0] HexTen    = 5'd10;
    localparam logic [4:0] HexNone   = 5'd16;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       is_value;
        logic       field_end;
        logic       pair_end;
        logic       query_end;
    } item_t;

    // all result items caused by one input byte
    typedef struct packed {
        item_t [MaxItems-1:0] items;
        logic  [ItemIdxW-1:0] last_idx;
    } group_t;

endpackage

>>> rtl/uqd_front.sv
`timescale 1ns / 1ps

module uqd_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        in_byte,
    input  logic              query_last,
    output uqd_pkg::group_t   grp,
    output logic              grp_valid
);

    typedef enum logic [1:0] {EscNone, EscPct, EscDigit} esc_t;

    typedef struct packed {
        esc_t                                    esc;
        logic [7:0]                              held;
        logic                                    inval;
        logic                                    popen;
        logic [7:0]                              hold_b;
        logic                                    hold_v;
        logic [uqd_pkg::ItemCntW-1:0]            cnt;
        uqd_pkg::item_t [uqd_pkg::MaxItems-1:0]  items;
    } ctx_t;

    esc_t       esc_reg,    esc_next;
    logic [7:0] held_reg,   held_next;
    logic       inval_reg,  inval_next;
    logic       popen_reg,  popen_next;
    logic [7:0] hold_b_reg, hold_b_next;
    logic       hold_v_reg, hold_v_next;

    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [4:0] r;
        r = uqd_pkg::HexNone;
        if (c >= uqd_pkg::ChZero && c <= uqd_pkg::ChNine)
            r = 5'(c - uqd_pkg::ChZero);
        else if (c >= uqd_pkg::ChLowA && c <= uqd_pkg::ChLowF)
            r = 5'(c - uqd_pkg::ChLowA) + uqd_pkg::HexTen;
        else if (c >= uqd_pkg::ChUpA && c <= uqd_pkg::ChUpF)
            r = 5'(c - uqd_pkg::ChUpA) + uqd_pkg::HexTen;
        return r;
    endfunction

    function automatic ctx_t f_put(input ctx_t ci, input logic [7:0] b, input logic has,
                                   input logic fe, input logic pe);
        ctx_t c;
        uqd_pkg::item_t it;
        c = ci;
        it.out_byte  = has ? b : 8'h00;
        it.has_byte  = has;
        it.is_value  = c.inval;
        it.field_end = fe;
        it.pair_end  = pe;
        it.query_end = 1'b0;
        if (c.cnt < uqd_pkg::ItemCntW'(uqd_pkg::MaxItems))
        begin
            c.items[c.cnt[uqd_pkg::ItemIdxW-1:0]] = it;
            c.cnt = c.cnt + 1'b1;
        end
        return c;
    endfunction

    // keep one byte back until we know whether it ends its field
    function automatic ctx_t f_emit(input ctx_t ci, input logic [7:0] b);
        ctx_t c;
        c = ci;
        if (c.hold_v)
            c = f_put(c, c.hold_b, 1'b1, 1'b0, 1'b0);
        c.hold_b = b;
        c.hold_v = 1'b1;
        return c;
    endfunction

    function automatic ctx_t f_close_field(input ctx_t ci, input logic pe);
        ctx_t c;
        c = ci;
        if (c.hold_v)
        begin
            c = f_put(c, c.hold_b, 1'b1, 1'b1, pe);
            c.hold_v = 1'b0;
        end
        else
        begin
            c = f_put(c, 8'h00, 1'b0, 1'b1, pe);
        end
        return c;
    endfunction

    function automatic ctx_t f_close_pair(input ctx_t ci);
        ctx_t c;
        c = ci;
        if (!c.inval)
        begin
            c = f_close_field(c, 1'b0);
            c.inval = 1'b1;
        end
        c = f_close_field(c, 1'b1);
        c.inval = 1'b0;
        c.popen = 1'b0;
        return c;
    endfunction

    function automatic ctx_t f_fresh(input ctx_t ci, input logic [7:0] b);
        ctx_t c;
        c = ci;
        if (b == uqd_pkg::ChAmp)
        begin
            if (c.popen)
                c = f_close_pair(c);
        end
        else
        begin
            c.popen = 1'b1;
            if (b == uqd_pkg::ChEqual)
            begin
                if (!c.inval)
                begin
                    c = f_close_field(c, 1'b0);
                    c.inval = 1'b1;
                end
                else
                begin
                    c = f_emit(c, b);
                end
            end
            else if (b == uqd_pkg::ChPercent)
            begin
                // an escape always yields a byte, so the held one cannot end the field
                if (c.hold_v)
                begin
                    c = f_put(c, c.hold_b, 1'b1, 1'b0, 1'b0);
                    c.hold_v = 1'b0;
                end
                c.esc = EscPct;
            end
            else if (b == uqd_pkg::ChPlus)
            begin
                c = f_emit(c, uqd_pkg::ChSpace);
            end
            else
            begin
                c = f_emit(c, b);
            end
        end
        return c;
    endfunction

    ctx_t                         c;
    logic [4:0]                   hv;
    logic [4:0]                   hv_held;
    logic [uqd_pkg::ItemCntW-1:0] last_n;
    uqd_pkg::item_t               bare;

    always_comb
    begin
        hv      = hex_of(in_byte);
        hv_held = hex_of(held_reg);
        c.esc    = esc_reg;
        c.held   = held_reg;
        c.inval  = inval_reg;
        c.popen  = popen_reg;
        c.hold_b = hold_b_reg;
        c.hold_v = hold_v_reg;
        c.cnt    = '0;
        c.items  = '0;

        unique case (esc_reg)
            EscPct:
            begin
                if (hv != uqd_pkg::HexNone)
                begin
                    c.held = in_byte;
                    c.esc  = EscDigit;
                end
                else
                begin
                    c.esc = EscNone;
                    c = f_emit(c, uqd_pkg::ChPercent);
                    c = f_fresh(c, in_byte);
                end
            end
            EscDigit:
            begin
                c.esc = EscNone;
                if (hv != uqd_pkg::HexNone)
                begin
                    c = f_emit(c, {hv_held[3:0], hv[3:0]});
                end
                else
                begin
                    c = f_emit(c, uqd_pkg::ChPercent);
                    c = f_emit(c, held_reg);
                    c = f_fresh(c, in_byte);
                end
            end
            default:
            begin
                c.esc = EscNone;
                c = f_fresh(c, in_byte);
            end
        endcase

        last_n = '0;
        bare   = '0;
        if (query_last)
        begin
            // dangling escape goes out literally
            if (c.esc == EscPct)
            begin
                c = f_emit(c, uqd_pkg::ChPercent);
            end
            else if (c.esc == EscDigit)
            begin
                c = f_emit(c, uqd_pkg::ChPercent);
                c = f_emit(c, c.held);
            end
            c.esc = EscNone;
            if (c.popen)
                c = f_close_pair(c);
            if (c.cnt == '0)
            begin
                c.items[0] = bare;
                c.cnt      = uqd_pkg::ItemCntW'(1);
            end
            last_n = c.cnt - 1'b1;
            c.items[last_n[uqd_pkg::ItemIdxW-1:0]].query_end = 1'b1;
            c.esc    = EscNone;
            c.held   = 8'h00;
            c.inval  = 1'b0;
            c.popen  = 1'b0;
            c.hold_b = 8'h00;
            c.hold_v = 1'b0;
        end

        esc_next    = c.esc;
        held_next   = c.held;
        inval_next  = c.inval;
        popen_next  = c.popen;
        hold_b_next = c.hold_b;
        hold_v_next = c.hold_v;
    end

    always_comb
    begin
        grp.items    = c.items;
        grp.last_idx = uqd_pkg::ItemIdxW'(c.cnt - 1'b1);
        grp_valid    = accept && (c.cnt != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg    <= EscNone;
            held_reg   <= 8'h00;
            inval_reg  <= 1'b0;
            popen_reg  <= 1'b0;
            hold_b_reg <= 8'h00;
            hold_v_reg <= 1'b0;
        end
        else if (accept)
        begin
            esc_reg    <= esc_next;
            held_reg   <= held_next;
            inval_reg  <= inval_next;
            popen_reg  <= popen_next;
            hold_b_reg <= hold_b_next;
            hold_v_reg <= hold_v_next;
        end
    end

endmodule

>>> rtl/uqd_fifo.sv
`timescale 1ns / 1ps

module uqd_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  uqd_pkg::group_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output uqd_pkg::group_t rd_data,
    output logic            empty
);

    uqd_pkg::group_t               mem [uqd_pkg::FifoDepth];
    logic [uqd_pkg::FifoPtrW-1:0]  wr_ptr_reg;
    logic [uqd_pkg::FifoPtrW-1:0]  rd_ptr_reg;
    logic [uqd_pkg::FifoCntW-1:0]  count_reg;
    logic                          do_wr;
    logic                          do_rd;

    assign full    = (count_reg == uqd_pkg::FifoCntW'(uqd_pkg::FifoDepth));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> rtl/uqd_back.sv
`timescale 1ns / 1ps

module uqd_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  uqd_pkg::group_t grp,
    input  logic            grp_empty,
    output logic            grp_rd,
    input  logic            pop,
    output logic            empty,
    output uqd_pkg::item_t  item
);

    uqd_pkg::group_t               cur_reg;
    logic                          cur_v_reg;
    logic [uqd_pkg::ItemIdxW-1:0]  idx_reg;
    logic                          take;
    logic                          done;
    logic                          reload;

    assign take   = pop && cur_v_reg;
    assign done   = take && (idx_reg == cur_reg.last_idx);
    // fetch the next group as the last item of the current one leaves, or when none is held
    assign reload = !cur_v_reg || done;
    assign grp_rd = reload && !grp_empty;
    assign empty  = !cur_v_reg;
    assign item   = cur_reg.items[idx_reg];

    always_ff @(posedge clk)
    begin
        if (grp_rd)
            cur_reg <= grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_v_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (reload)
        begin
            cur_v_reg <= !grp_empty;
            idx_reg   <= '0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

endmodule

>>> rtl/url_query_string_decoder_core.sv
`timescale 1ns / 1ps
// path: results of a byte pass the 4-deep group queue, then the output group register
// throughput: one byte per cycle while each byte yields at most one result and the queue
// has room; a byte that yields n results holds the output side until all n are popped
// reset: rst_n clears parser state, queue and output register; the decoder starts in a key
module url_query_string_decoder_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_byte,
    input  logic       query_last,
    input  logic       push,
    output logic       full,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       is_value,
    output logic       field_end,
    output logic       pair_end,
    output logic       query_end,
    output logic       empty,
    input  logic       pop
);

    uqd_pkg::group_t front_grp;
    logic            front_valid;
    uqd_pkg::group_t fifo_grp;
    logic            fifo_full;
    logic            fifo_empty;
    logic            fifo_rd;
    uqd_pkg::item_t  item;
    logic            accept;

    assign full   = fifo_full;
    assign accept = push && !fifo_full;

    uqd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .query_last (query_last),
        .grp        (front_grp),
        .grp_valid  (front_valid)
    );

    uqd_fifo u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_data (front_grp),
        .full    (fifo_full),
        .rd_en   (fifo_rd),
        .rd_data (fifo_grp),
        .empty   (fifo_empty)
    );

    uqd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp       (fifo_grp),
        .grp_empty (fifo_empty),
        .grp_rd    (fifo_rd),
        .pop       (pop),
        .empty     (empty),
        .item      (item)
    );

    assign out_byte  = item.out_byte;
    assign has_byte  = item.has_byte;
    assign is_value  = item.is_value;
    assign field_end = item.field_end;
    assign pair_end  = item.pair_end;
    assign query_end = item.query_end;

endmodule
